// ===== hdl/aqcg_pkg.sv =====
// Package for the aligned quad corner generator: stage map, the pipeline item
// record and the output saturation helper. No dependencies.
package aqcg_pkg;

  localparam int CoordWidth = 24;
  localparam int UnitWidth  = 16;
  localparam int SizeWidth  = 16;
  localparam int OutWidth   = 28;
  localparam int TolWidth   = 28;
  localparam int FracBits   = 14;
  localparam int NormBits   = 30;

  localparam logic [TolWidth-1:0] TolReset = 28'd2684;

  localparam logic [1:0] AlignMid = 2'd1;
  localparam logic [1:0] AlignFar = 2'd2;

  localparam int StDot    = 1;
  localparam int StRej    = 2;
  localparam int StMag    = 3;
  localparam int StMax    = 4;
  localparam int StLen    = 5;
  localparam int StShift  = 6;
  localparam int StSquare = 7;
  localparam int StSum    = 8;
  localparam int StSqrt0  = 9;
  localparam int SqrtSteps = 31;
  localparam int StDivIn  = StSqrt0 + SqrtSteps;
  localparam int StDiv0   = StDivIn + 1;
  localparam int DivSteps = 16;
  localparam int StSel    = StDiv0 + DivSteps;
  localparam int StCrossP = StSel + 1;
  localparam int StCross  = StSel + 2;
  localparam int StScale  = StSel + 3;
  localparam int StCorner = StSel + 4;
  localparam int NumStages = StCorner + 1;

  typedef struct packed {
    logic [2:0][CoordWidth-1:0] a;
    logic [2:0][UnitWidth-1:0]  n;
    logic [2:0][UnitWidth-1:0]  u;
    logic [SizeWidth-1:0]       w;
    logic [SizeWidth-1:0]       h;
    logic [1:0]                 hc;
    logic [1:0]                 vc;
    logic [2:0][31:0]           p;
    logic [33:0]                dot;
    logic                       ortho;
    logic [2:0][49:0]           r;
    logic [2:0][48:0]           mag;
    logic [2:0]                 neg;
    logic                       zero;
    logic [48:0]                mx;
    logic [5:0]                 bl;
    logic [2:0][NormBits-1:0]   nm;
    logic [2:0][59:0]           sq;
    logic [61:0]                sv;
    logic [62:0]                sr;
    logic [31:0]                len;
    logic [2:0][44:0]           rem;
    logic [2:0][15:0]           q;
    logic [2:0][16:0]           s;
    logic [5:0][32:0]           cp;
    logic [2:0][33:0]           c;
    logic [2:0][50:0]           lr;
    logic [2:0][33:0]           bt;
    logic [3:0][2:0][OutWidth-1:0] crn;
  } item_t;

  function automatic logic [OutWidth-1:0] sat_out(input logic signed [31:0] v);
    logic [OutWidth-1:0] res;
    if (v > 32'sd134217727) res = {1'b0, {(OutWidth-1){1'b1}}};
    else if (v < -32'sd134217728) res = {1'b1, {(OutWidth-1){1'b0}}};
    else res = v[OutWidth-1:0];
    return res;
  endfunction

endpackage

// ===== hdl/aligned_quad_corner_generator.sv =====
// Aligned quad corner generator top level: one flat pipeline of item records.
// Depends on aqcg_pkg.
//
// Takes one request per cycle while in_ready is high and raises out_valid for its
// four corners once it has passed through 62 register stages. The depth is set by
// the 31-step square root and the 16-step divider that renormalize a non-orthogonal
// up vector; every request goes through them. When a finished beat waits with
// out_ready low the whole pipeline holds, and in_ready drops with it.
// dot_tolerance may be rewritten only while the pipeline is empty.
module aligned_quad_corner_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [27:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] anchor_x,
  input  logic [23:0] anchor_y,
  input  logic [23:0] anchor_z,
  input  logic [15:0] normal_x,
  input  logic [15:0] normal_y,
  input  logic [15:0] normal_z,
  input  logic [15:0] up_x,
  input  logic [15:0] up_y,
  input  logic [15:0] up_z,
  input  logic [15:0] quad_width,
  input  logic [15:0] quad_height,
  input  logic [3:0]  align_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] top_left_x,
  output logic [27:0] top_left_y,
  output logic [27:0] top_left_z,
  output logic [27:0] top_right_x,
  output logic [27:0] top_right_y,
  output logic [27:0] top_right_z,
  output logic [27:0] bottom_left_x,
  output logic [27:0] bottom_left_y,
  output logic [27:0] bottom_left_z,
  output logic [27:0] bottom_right_x,
  output logic [27:0] bottom_right_y,
  output logic [27:0] bottom_right_z
);

  localparam int N = aqcg_pkg::NumStages;

  logic [27:0]      dot_tolerance;
  aqcg_pkg::item_t  stg [N];
  aqcg_pkg::item_t  nxt [N];
  logic [N-1:0]     vld;
  logic             ce;

  assign ce        = !vld[N-1] || out_ready;
  assign in_ready  = ce;
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_tolerance <= aqcg_pkg::TolReset;
    end else if (cfg_we) begin
      dot_tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < N; k++) stg[k] <= nxt[k];
    end
  end

  always_comb begin
    aqcg_pkg::item_t       d;
    logic signed [15:0]    ns, us;
    logic signed [16:0]    sa, sb;
    logic signed [33:0]    dts;
    logic [33:0]           adot;
    logic signed [49:0]    rs;
    logic [62:0]           bit_v, t;
    logic [47:0]           dv;
    logic signed [51:0]    lrs, lr8, lrh;
    logic signed [35:0]    bts, bt8, bth;
    logic signed [31:0]    tl, tr, bl, br;
    int                    ii, jj;

    d = '0;
    d.a  = {anchor_z, anchor_y, anchor_x};
    d.n  = {normal_z, normal_y, normal_x};
    d.u  = {up_z, up_y, up_x};
    d.w  = quad_width;
    d.h  = quad_height;
    d.hc = align_code[1:0];
    d.vc = align_code[3:2];
    for (int i = 0; i < 3; i++) begin
      ns = $signed(d.n[i]);
      us = $signed(d.u[i]);
      d.p[i] = 32'(ns * us);
    end
    nxt[0] = d;

    for (int k = 1; k < N; k++) begin
      d = stg[k-1];
      if (k == aqcg_pkg::StDot) begin
        dts = 34'($signed(d.p[0])) + 34'($signed(d.p[1])) + 34'($signed(d.p[2]));
        adot = dts[33] ? 34'(-dts) : dts;
        d.dot = dts;
        d.ortho = adot <= {6'b0, dot_tolerance};
      end else if (k == aqcg_pkg::StRej) begin
        dts = $signed(d.dot);
        for (int i = 0; i < 3; i++) begin
          ns = $signed(d.n[i]);
          rs = $signed({{6{d.u[i][15]}}, d.u[i], 28'b0}) - 50'(dts * ns);
          d.r[i] = rs;
        end
      end else if (k == aqcg_pkg::StMag) begin
        for (int i = 0; i < 3; i++) begin
          rs = $signed(d.r[i]);
          d.neg[i] = rs[49];
          d.mag[i] = rs[49] ? 49'(-rs) : 49'(rs);
        end
        d.zero = (d.r[0] == '0) && (d.r[1] == '0) && (d.r[2] == '0);
      end else if (k == aqcg_pkg::StMax) begin
        d.mx = d.mag[0];
        if (d.mag[1] > d.mx) d.mx = d.mag[1];
        if (d.mag[2] > d.mx) d.mx = d.mag[2];
      end else if (k == aqcg_pkg::StLen) begin
        d.bl = '0;
        for (int b = 0; b < 49; b++) begin
          if (d.mx[b]) d.bl = 6'(b + 1);
        end
      end else if (k == aqcg_pkg::StShift) begin
        for (int i = 0; i < 3; i++) begin
          if (d.bl > 6'd30) d.nm[i] = 30'(d.mag[i] >> (d.bl - 6'd30));
          else d.nm[i] = 30'(d.mag[i] << (6'd30 - d.bl));
        end
      end else if (k == aqcg_pkg::StSquare) begin
        for (int i = 0; i < 3; i++) d.sq[i] = 60'(d.nm[i]) * 60'(d.nm[i]);
      end else if (k == aqcg_pkg::StSum) begin
        d.sv = 62'(d.sq[0]) + 62'(d.sq[1]) + 62'(d.sq[2]);
        d.sr = '0;
      end else if (k >= aqcg_pkg::StSqrt0 && k < aqcg_pkg::StDivIn) begin
        ii = aqcg_pkg::StDivIn - 1 - k;
        bit_v = 63'(1) << (2 * ii);
        t = d.sr + bit_v;
        if ({1'b0, d.sv} >= t) begin
          d.sv = d.sv - t[61:0];
          d.sr = (d.sr >> 1) + bit_v;
        end else begin
          d.sr = d.sr >> 1;
        end
      end else if (k == aqcg_pkg::StDivIn) begin
        d.len = d.sr[31:0];
        for (int i = 0; i < 3; i++) begin
          d.rem[i] = (45'(d.nm[i]) << 14) + 45'(d.len >> 1);
          d.q[i] = '0;
        end
      end else if (k >= aqcg_pkg::StDiv0 && k < aqcg_pkg::StSel) begin
        jj = aqcg_pkg::StSel - 1 - k;
        dv = 48'(d.len) << jj;
        for (int i = 0; i < 3; i++) begin
          if ({3'b0, d.rem[i]} >= dv) begin
            d.rem[i] = d.rem[i] - dv[44:0];
            d.q[i][jj] = 1'b1;
          end
        end
      end else if (k == aqcg_pkg::StSel) begin
        for (int i = 0; i < 3; i++) begin
          if (d.ortho) d.s[i] = {d.u[i][15], d.u[i]};
          else if (d.zero) d.s[i] = '0;
          else if (d.neg[i]) d.s[i] = 17'(-$signed({1'b0, d.q[i]}));
          else d.s[i] = {1'b0, d.q[i]};
        end
      end else if (k == aqcg_pkg::StCrossP) begin
        sa = $signed(d.s[1]); ns = $signed(d.n[2]); d.cp[0] = 33'(sa * ns);
        sa = $signed(d.s[2]); ns = $signed(d.n[1]); d.cp[1] = 33'(sa * ns);
        sa = $signed(d.s[2]); ns = $signed(d.n[0]); d.cp[2] = 33'(sa * ns);
        sa = $signed(d.s[0]); ns = $signed(d.n[2]); d.cp[3] = 33'(sa * ns);
        sa = $signed(d.s[0]); ns = $signed(d.n[1]); d.cp[4] = 33'(sa * ns);
        sa = $signed(d.s[1]); ns = $signed(d.n[0]); d.cp[5] = 33'(sa * ns);
      end else if (k == aqcg_pkg::StCross) begin
        for (int i = 0; i < 3; i++) begin
          d.c[i] = 34'($signed(d.cp[2*i])) - 34'($signed(d.cp[2*i+1]));
        end
      end else if (k == aqcg_pkg::StScale) begin
        for (int i = 0; i < 3; i++) begin
          d.lr[i] = 51'($signed(d.c[i]) * $signed({1'b0, d.w}));
          sb = $signed(d.s[i]);
          d.bt[i] = 34'(sb * $signed({1'b0, d.h}));
        end
      end else if (k == aqcg_pkg::StCorner) begin
        for (int i = 0; i < 3; i++) begin
          lrs = 52'($signed(d.lr[i]));
          bts = 36'($signed(d.bt[i]));
          lr8 = (lrs + (52'sd1 <<< 27)) >>> 28;
          lrh = (lrs + (52'sd1 <<< 28)) >>> 29;
          bt8 = (bts + (36'sd1 <<< 13)) >>> 14;
          bth = (bts + (36'sd1 <<< 14)) >>> 15;
          tl = 32'($signed(d.a[i]));
          if (d.hc == aqcg_pkg::AlignMid) tl = tl - 32'(lrh);
          else if (d.hc == aqcg_pkg::AlignFar) tl = tl - 32'(lr8);
          if (d.vc == aqcg_pkg::AlignMid) tl = tl + 32'(bth);
          else if (d.vc == aqcg_pkg::AlignFar) tl = tl + 32'(bt8);
          tr = tl + 32'(lr8);
          bl = tl - 32'(bt8);
          br = tr - 32'(bt8);
          d.crn[0][i] = aqcg_pkg::sat_out(tl);
          d.crn[1][i] = aqcg_pkg::sat_out(tr);
          d.crn[2][i] = aqcg_pkg::sat_out(bl);
          d.crn[3][i] = aqcg_pkg::sat_out(br);
        end
      end
      nxt[k] = d;
    end
  end

  assign top_left_x     = stg[N-1].crn[0][0];
  assign top_left_y     = stg[N-1].crn[0][1];
  assign top_left_z     = stg[N-1].crn[0][2];
  assign top_right_x    = stg[N-1].crn[1][0];
  assign top_right_y    = stg[N-1].crn[1][1];
  assign top_right_z    = stg[N-1].crn[1][2];
  assign bottom_left_x  = stg[N-1].crn[2][0];
  assign bottom_left_y  = stg[N-1].crn[2][1];
  assign bottom_left_z  = stg[N-1].crn[2][2];
  assign bottom_right_x = stg[N-1].crn[3][0];
  assign bottom_right_y = stg[N-1].crn[3][1];
  assign bottom_right_z = stg[N-1].crn[3][2];

endmodule
